### hw/rtl/fmv_pkg.sv
// Package of the four-operator FM voice: types, constants, wiring tables and sine function.
`default_nettype none
package fmv_pkg;

  localparam int unsigned SIG_W = 20;
  localparam logic signed [SIG_W-1:0] SIG_MAX = 20'sd524287;
  localparam logic signed [SIG_W-1:0] SIG_MIN = -20'sd524288;
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [11:0] FB_MAX = 12'd2048;

  localparam logic [2:0] REG_ALGORITHM = 3'd0;
  localparam logic [2:0] REG_INC0 = 3'd1;
  localparam logic [2:0] REG_INC1 = 3'd2;
  localparam logic [2:0] REG_INC2 = 3'd3;
  localparam logic [2:0] REG_INC3 = 3'd4;
  localparam logic [2:0] REG_LEVELS = 3'd5;
  localparam logic [2:0] REG_FEEDBACK = 3'd6;

  localparam logic CMD_RENDER = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MOD, ST_SINE, ST_SCALE, ST_PROD, ST_WRITE, ST_MIX
  } state_t;

  typedef struct packed {
    logic [SIG_W-1:0] last;
    logic [SIG_W-1:0] older;
  } hist_t;

  function automatic logic [3:0] wire_mods(input logic [2:0] alg, input logic [1:0] op);
    logic [3:0] r;
    r = 4'h0;
    case (alg)
      3'd0: if (op == 2'd0) r = 4'h2;
      3'd1: if (op == 2'd0) r = 4'h2; else if (op == 2'd1) r = 4'h4;
      3'd2: if (op == 2'd0) r = 4'h2; else if (op == 2'd1) r = 4'h4;
            else if (op == 2'd2) r = 4'h8;
      3'd3: if (op == 2'd0) r = 4'h2; else if (op == 2'd2) r = 4'h8;
      3'd4: if (op == 2'd0) r = 4'h6;
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] wire_carriers(input logic [2:0] alg);
    logic [3:0] r;
    case (alg)
      3'd0, 3'd1, 3'd2, 3'd4: r = 4'h1;
      3'd3: r = 4'h5;
      default: r = 4'h3;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] quarter_sine_q30(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] p;
    u2 = (u * u) >> 30;
    p = 64'd172272;
    p = 64'd5026997 - ((u2 * p) >> 30);
    p = 64'd85569306 - ((u2 * p) >> 30);
    p = 64'd693598671 - ((u2 * p) >> 30);
    p = 64'd1686629713 - ((u2 * p) >> 30);
    return (u * p) >> 30;
  endfunction

  // Table entry for a sine of 2^tb entries, evaluated at elaboration for each index.
  function automatic logic signed [17:0] sine_entry(input int tb, input int idx);
    int qb;
    int qsize;
    int quad;
    int r;
    logic [63:0] s;
    qb = tb - 2;
    qsize = 1 << qb;
    quad = idx >> qb;
    r = idx & (qsize - 1);
    if ((quad & 1) != 0) r = qsize - r;
    s = (quarter_sine_q30(64'(r) << (30 - qb)) + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return (quad >= 2) ? -18'(s) : 18'(s);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/fmv_sine_rom.sv
// Registered sine table of the four-operator FM voice.
`default_nettype none
module fmv_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic [SINE_TABLE_BITS-1:0] addr,
  output logic signed [17:0]              data_r
);
  localparam int DEPTH = 1 << SINE_TABLE_BITS;
  logic signed [17:0] rom [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rom[i] = fmv_pkg::sine_entry(SINE_TABLE_BITS, i);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= rom[addr];
  end
endmodule
`default_nettype wire

### hw/rtl/fm_four_operator_voice.sv
// Top level of the four-operator FM voice: sequencer, state memories and arithmetic.
//  channel | direction | transaction
//  in_     | slave     | command (tuser), bend ratio and four envelopes (tdata)
//  out_    | master    | one signed 20-bit sample per input transaction
//  cfg_    | write     | index 0..6, 64-bit data, no read-back
// A render runs the operators from 3 down to 0 through one shared multiply path and the phase
// and history memories; each active operator passes READ, MOD, SINE, SCALE, PROD and WRITE,
// a skipped operator (level zero) only READ, and the render ends in MIX before output.
// A start transaction clears the memories' valid bits and gives a zero sample. Reset clears
// control state and the memories' valid bits. A stalled output holds the block idle, with
// in_tready low, until taken.
`default_nettype none
module fm_four_operator_voice #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int PHASE_BITS = 28
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,  // bend_ratio, envelope_op0..envelope_op3
  input  wire logic        in_tuser,  // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // sample, zero fill
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  localparam int SW = fmv_pkg::SIG_W;
  localparam int TB = SINE_TABLE_BITS;
  localparam int PB = PHASE_BITS;

  logic [2:0] alg_r;
  logic [31:0] inc_r [4];
  logic [63:0] levels_r;
  logic [47:0] fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alg_r <= '0;
      for (int i = 0; i < 4; i++) inc_r[i] <= '0;
      levels_r <= '0;
      fb_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fmv_pkg::REG_ALGORITHM: alg_r <= cfg_data[2:0];
        fmv_pkg::REG_INC0: inc_r[0] <= cfg_data[31:0];
        fmv_pkg::REG_INC1: inc_r[1] <= cfg_data[31:0];
        fmv_pkg::REG_INC2: inc_r[2] <= cfg_data[31:0];
        fmv_pkg::REG_INC3: inc_r[3] <= cfg_data[31:0];
        fmv_pkg::REG_LEVELS: levels_r <= cfg_data;
        fmv_pkg::REG_FEEDBACK: fb_r <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // State memories written at the current operator and read, registered, at the next one,
  // so the data is ready when that operator starts; valid bits stand for the zero reset
  // and the start clear.
  logic [PB-1:0] phase_mem [4];
  fmv_pkg::hist_t hist_mem [4];
  logic [3:0] vld_r, vld_nxt;
  logic [PB-1:0] phase_rd_r;
  fmv_pkg::hist_t hist_rd_r;
  logic mem_we;
  logic [PB-1:0] phase_wd;
  fmv_pkg::hist_t hist_wd;

  fmv_pkg::state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [15:0] ratio_r;
  logic [15:0] env_r [4];
  logic cmd_r;
  logic signed [SW-1:0] outs_r [4];
  logic signed [SW-1:0] outs_nxt [4];
  logic signed [SW-1:0] mod_r, mod_nxt;
  logic [PB-1:0] angle_r, angle_nxt;
  logic signed [SW-1:0] y_r, y_nxt;
  logic [PB-1:0] step_r, step_nxt;
  logic signed [SW-1:0] sample_r, sample_nxt;
  logic out_valid_r, out_valid_nxt;
  logic done_op;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      phase_mem[op_r] <= phase_wd;
      hist_mem[op_r] <= hist_wd;
    end
    phase_rd_r <= phase_mem[op_nxt];
    hist_rd_r <= hist_mem[op_nxt];
  end

  logic [2:0] alg_eff;
  assign alg_eff = (alg_r > 3'd5) ? 3'd5 : alg_r;

  logic [15:0] level;
  logic [11:0] fb_raw, fb_amt;
  logic [PB-1:0] ph;
  fmv_pkg::hist_t hs;
  logic [3:0] mods;
  logic [3:0] car;
  always_comb begin
    level = levels_r[16*op_r +: 16];
    fb_raw = fb_r[12*op_r +: 12];
    fb_amt = (fb_raw > fmv_pkg::FB_MAX) ? fmv_pkg::FB_MAX : fb_raw;
    ph = vld_r[op_r] ? phase_rd_r : '0;
    hs = vld_r[op_r] ? hist_rd_r : '0;
    mods = fmv_pkg::wire_mods(alg_eff, op_r);
    car = fmv_pkg::wire_carriers(alg_eff);
  end

  // Modulation sum and feedback.
  logic signed [23:0] msum;
  logic signed [SW:0] hsum;
  logic signed [33:0] fbp;
  logic [33:0] fbmag;
  logic signed [24:0] mtot;
  always_comb begin
    msum = '0;
    for (int m = 0; m < 4; m++) begin
      if (mods[m]) msum = msum + 24'(outs_r[m]);
    end
    hsum = (SW+1)'($signed(hs.last)) + (SW+1)'($signed(hs.older));
    fbp = $signed({22'd0, fb_amt}) * 34'(hsum);
    fbmag = fbp[33] ? 34'(-fbp) : 34'(fbp);
    fbmag = fbmag >> 10;
    mtot = 25'(msum) + (fbp[33] ? -25'(fbmag) : 25'(fbmag));
    if (mtot > 25'(fmv_pkg::SIG_MAX)) mod_nxt = fmv_pkg::SIG_MAX;
    else if (mtot < 25'(fmv_pkg::SIG_MIN)) mod_nxt = fmv_pkg::SIG_MIN;
    else mod_nxt = SW'(mtot);
  end

  // Angle from modulation: one 20x32 product.
  logic [SW-1:0] mmag;
  logic [51:0] offp;
  logic [PB-1:0] off;
  always_comb begin
    mmag = mod_r[SW-1] ? SW'(-mod_r) : SW'(mod_r);
    offp = 52'(mmag) * 52'(fmv_pkg::INV_TWO_PI_Q32);
    off = PB'(offp >> (47 - PB));
    angle_nxt = mod_r[SW-1] ? ph - off : ph + off;
  end

  logic signed [17:0] sine_r;
  fmv_sine_rom #(.SINE_TABLE_BITS(TB)) u_rom (
    .clk(clk), .addr(angle_r[PB-1 -: TB]), .data_r(sine_r)
  );

  // Scale: sine*envelope registered, then *level.
  logic signed [34:0] se_r;
  logic signed [34:0] se_nxt;
  logic signed [51:0] prod;
  logic [51:0] pmag;
  logic [51:0] pq;
  logic signed [52:0] ys;
  always_comb begin
    se_nxt = 35'(sine_r) * $signed({19'd0, env_r[op_r]});
    prod = 52'(se_r) * $signed({36'd0, level});
    pmag = prod[51] ? 52'(-prod) : 52'(prod);
    pq = pmag >> 29;
    ys = prod[51] ? -53'(pq) : 53'(pq);
    if (ys > 53'(fmv_pkg::SIG_MAX)) y_nxt = fmv_pkg::SIG_MAX;
    else if (ys < 53'(fmv_pkg::SIG_MIN)) y_nxt = fmv_pkg::SIG_MIN;
    else y_nxt = SW'(ys);
  end

  logic [47:0] stepp;
  assign stepp = 48'(inc_r[op_r]) * 48'(ratio_r);
  assign step_nxt = PB'(stepp >> (40 - PB));

  logic signed [22:0] mix;
  logic signed [22:0] mixh;
  always_comb begin
    mix = '0;
    for (int k = 0; k < 4; k++) if (car[k]) mix = mix + 23'(outs_r[k]);
    mixh = ($countones(car) == 2) ? (mix[22] ? -((-mix) >>> 1) : mix >>> 1) : mix;
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    vld_nxt = vld_r;
    mem_we = 1'b0;
    phase_wd = ph + step_r;
    hist_wd.last = y_r;
    hist_wd.older = hs.last;
    for (int k = 0; k < 4; k++) outs_nxt[k] = outs_r[k];
    sample_nxt = sample_r;
    out_valid_nxt = out_valid_r;
    in_tready = 1'b0;
    done_op = 1'b0;
    case (state_r)
      fmv_pkg::ST_IDLE: begin
        in_tready = !out_valid_r;
        if (in_tvalid && !out_valid_r) begin
          if (in_tuser == fmv_pkg::CMD_START) begin
            vld_nxt = '0;
            sample_nxt = '0;
            out_valid_nxt = 1'b1;
          end else begin
            op_nxt = 2'd3;
            for (int k = 0; k < 4; k++) outs_nxt[k] = '0;
            state_nxt = fmv_pkg::ST_READ;
          end
        end
      end
      fmv_pkg::ST_READ: begin
        if (level == 16'd0) done_op = 1'b1;
        else state_nxt = fmv_pkg::ST_MOD;
      end
      fmv_pkg::ST_MOD: state_nxt = fmv_pkg::ST_SINE;
      fmv_pkg::ST_SINE: state_nxt = fmv_pkg::ST_SCALE;
      fmv_pkg::ST_SCALE: state_nxt = fmv_pkg::ST_PROD;
      fmv_pkg::ST_PROD: state_nxt = fmv_pkg::ST_WRITE;
      fmv_pkg::ST_WRITE: begin
        mem_we = 1'b1;
        vld_nxt[op_r] = 1'b1;
        outs_nxt[op_r] = y_r;
        done_op = 1'b1;
      end
      fmv_pkg::ST_MIX: begin
        if (mixh > 23'(fmv_pkg::SIG_MAX)) sample_nxt = fmv_pkg::SIG_MAX;
        else if (mixh < 23'(fmv_pkg::SIG_MIN)) sample_nxt = fmv_pkg::SIG_MIN;
        else sample_nxt = SW'(mixh);
        out_valid_nxt = 1'b1;
        state_nxt = fmv_pkg::ST_IDLE;
      end
      default: state_nxt = fmv_pkg::ST_IDLE;
    endcase
    if (done_op) begin
      if (op_r == 2'd0) state_nxt = fmv_pkg::ST_MIX;
      else begin
        op_nxt = op_r - 2'd1;
        state_nxt = fmv_pkg::ST_READ;
      end
    end
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmv_pkg::ST_IDLE;
      op_r <= '0;
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      vld_r <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == fmv_pkg::ST_IDLE && in_tvalid && in_tready) begin
      ratio_r <= in_tdata[15:0];
      for (int k = 0; k < 4; k++) env_r[k] <= in_tdata[16+16*k +: 16];
      cmd_r <= in_tuser;
    end
    for (int k = 0; k < 4; k++) outs_r[k] <= outs_nxt[k];
    mod_r <= mod_nxt;
    angle_r <= angle_nxt;
    se_r <= se_nxt;
    y_r <= y_nxt;
    step_r <= step_nxt;
    sample_r <= sample_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {4'd0, sample_r};

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != fmv_pkg::ST_IDLE) |-> !in_tready;
  endproperty
  assert property (p_no_accept_busy) else $error("input taken while rendering");

  property p_mix_gives_output;
    @(posedge clk) disable iff (!rst_n) (state_r == fmv_pkg::ST_MIX) |=> out_tvalid;
  endproperty
  assert property (p_mix_gives_output) else $error("mix produced no output");

  property p_start_clears;
    @(posedge clk) disable iff (!rst_n)
      (in_tvalid && in_tready && in_tuser == fmv_pkg::CMD_START) |=>
        (vld_r == 4'd0 && out_tvalid);
  endproperty
  assert property (p_start_clears) else $error("start did not clear state");

  property p_write_only_in_write;
    @(posedge clk) disable iff (!rst_n) mem_we |-> (state_r == fmv_pkg::ST_WRITE);
  endproperty
  assert property (p_write_only_in_write) else $error("stray memory write");

  property p_cmd_render_held;
    @(posedge clk) disable iff (!rst_n)
      (state_r == fmv_pkg::ST_MOD) |-> (cmd_r == fmv_pkg::CMD_RENDER);
  endproperty
  assert property (p_cmd_render_held) else $error("start command rendered");
endmodule
`default_nettype wire

### tb/sv/tb_fm_four_operator_voice.sv
// Self-checking testbench of the four-operator FM voice: directed table, then random phases.
`default_nettype none
module tb_fm_four_operator_voice;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;  // bend_ratio, envelope_op0..envelope_op3
  logic        in_tuser = 1'b0;  // command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // sample, zero fill
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  fm_four_operator_voice u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register copies.
  int                 sine_q [1024];
  logic [3:0]         mod_wiring [6][4];
  logic [3:0]         carrier_set [6];
  logic [2:0]         alg_r;
  logic [31:0]        inc_r [4];
  logic [63:0]        levels_r;
  logic [47:0]        fb_r;
  logic [27:0]        phase_r [4];
  logic signed [19:0] last_r [4];
  logic signed [19:0] older_r [4];

  logic signed [19:0] sample_q [$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 calm = 1'b0;

  function automatic longint trunc_shift(input longint v, input int sh);
    longint unsigned m;
    m = v < 0 ? longint'(-v) : v;
    m = m >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [19:0] clip20(input longint v);
    if (v > 524287) return fmv_pkg::SIG_MAX;
    if (v < -524288) return fmv_pkg::SIG_MIN;
    return v[19:0];
  endfunction

  function automatic longint unsigned quarter_wave(input longint unsigned u);
    longint unsigned u2;
    longint unsigned p;
    u2 = (u * u) >> 30;
    p = 172272;
    p = 64'd5026997 - ((u2 * p) >> 30);
    p = 64'd85569306 - ((u2 * p) >> 30);
    p = 64'd693598671 - ((u2 * p) >> 30);
    p = 64'd1686629713 - ((u2 * p) >> 30);
    return (u * p) >> 30;
  endfunction

  function automatic void clear_voice();
    for (int i = 0; i < 4; i++) begin
      phase_r[i] = '0;
      last_r[i] = '0;
      older_r[i] = '0;
    end
  endfunction

  function automatic logic signed [19:0] render_sample(input logic cmd,
      input logic [15:0] ratio, input logic [15:0] env [4]);
    int                 a;
    int                 carriers;
    longint             modv;
    longint             prod;
    longint             mix;
    longint unsigned    mag;
    longint unsigned    off;
    longint unsigned    ang;
    longint unsigned    lvl;
    longint unsigned    fbv;
    logic signed [19:0] y;
    logic signed [19:0] outs [4];
    if (cmd == fmv_pkg::CMD_START) begin
      clear_voice();
      return '0;
    end
    a = alg_r > 5 ? 5 : alg_r;
    mix = 0;
    carriers = 0;
    for (int i = 3; i >= 0; i--) begin
      outs[i] = '0;
      lvl = (levels_r >> (16 * i)) & 64'hFFFF;
      if (lvl == 0) continue;
      modv = 0;
      for (int m = i + 1; m < 4; m++)
        if (mod_wiring[a][i][m]) modv += outs[m];
      fbv = (fb_r >> (12 * i)) & 64'hFFF;
      if (fbv > fmv_pkg::FB_MAX) fbv = fmv_pkg::FB_MAX;
      if (fbv > 0)
        modv += trunc_shift(longint'(fbv) * (longint'(last_r[i]) + longint'(older_r[i])), 10);
      modv = clip20(modv);
      mag = modv < 0 ? longint'(-modv) : modv;
      off = (mag * 64'd683565276) >> 19;
      ang = modv < 0 ? phase_r[i] - off : phase_r[i] + off;
      ang = ang & 64'hFFFFFFF;
      prod = longint'(sine_q[ang >> 18]) * longint'({48'd0, env[i]}) * longint'(lvl);
      y = clip20(trunc_shift(prod, 29));
      phase_r[i] = phase_r[i] + 28'((longint'({32'd0, inc_r[i]}) * ratio) >> 12);
      older_r[i] = last_r[i];
      last_r[i] = y;
      outs[i] = y;
      if (carrier_set[a][i]) mix += y;
    end
    for (int i = 0; i < 4; i++) if (carrier_set[a][i]) carriers++;
    if (carriers == 2) mix = trunc_shift(mix, 1);
    return clip20(mix);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      fmv_pkg::REG_ALGORITHM: alg_r = val[2:0];
      fmv_pkg::REG_INC0: inc_r[0] = val[31:0];
      fmv_pkg::REG_INC1: inc_r[1] = val[31:0];
      fmv_pkg::REG_INC2: inc_r[2] = val[31:0];
      fmv_pkg::REG_INC3: inc_r[3] = val[31:0];
      fmv_pkg::REG_LEVELS: levels_r = val;
      fmv_pkg::REG_FEEDBACK: fb_r = val[47:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_voice(input logic [2:0] alg, input logic [31:0] i0, input logic [31:0] i1,
      input logic [31:0] i2, input logic [31:0] i3, input logic [63:0] lv, input logic [63:0] fb);
    write_reg(fmv_pkg::REG_ALGORITHM, {61'd0, alg});
    write_reg(fmv_pkg::REG_INC0, {32'd0, i0});
    write_reg(fmv_pkg::REG_INC1, {32'd0, i1});
    write_reg(fmv_pkg::REG_INC2, {32'd0, i2});
    write_reg(fmv_pkg::REG_INC3, {32'd0, i3});
    write_reg(fmv_pkg::REG_LEVELS, lv);
    write_reg(fmv_pkg::REG_FEEDBACK, fb);
    write_reg(REG_UNUSED, 64'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [15:0] ratio, input logic [15:0] env [4],
      input bit typed, input logic signed [19:0] typed_val);
    logic signed [19:0] pred;
    if (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {env[3], env[2], env[1], env[0], ratio};
    do @(posedge clk); while (!in_tready);
    pred = render_sample(cmd, ratio, env);
    sample_q.push_back(typed ? typed_val : pred);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected sample %0d", $time, $signed(out_tdata[19:0]));
        errors++;
      end else begin
        if (out_tdata[19:0] !== sample_q[0]) begin
          $display("%0t: sample expected %0d actual %0d", $time, sample_q[0],
                   $signed(out_tdata[19:0]));
          errors++;
        end
        void'(sample_q.pop_front());
      end
    end
    out_tready <= calm || $urandom_range(99) >= 23;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("fm_four_operator_voice regression: fail");
      $finish;
    end
  end

  typedef struct {
    logic               cmd;
    logic [15:0]        ratio;
    logic [15:0]        env [4];
    bit                 typed;
    logic signed [19:0] val;
  } stim_row_t;

  stim_row_t plan [12];

  initial begin
    logic [15:0] env [4];
    logic [63:0] lv;
    logic [63:0] fb;
    int qb;
    int r;
    int quad;
    longint unsigned s;
    mod_wiring = '{'{4'h2, 4'h0, 4'h0, 4'h0}, '{4'h2, 4'h4, 4'h0, 4'h0},
                   '{4'h2, 4'h4, 4'h8, 4'h0}, '{4'h2, 4'h0, 4'h8, 4'h0},
                   '{4'h6, 4'h0, 4'h0, 4'h0}, '{4'h0, 4'h0, 4'h0, 4'h0}};
    carrier_set = '{4'h1, 4'h1, 4'h1, 4'h5, 4'h1, 4'h3};
    qb = 8;
    for (int idx = 0; idx < 1024; idx++) begin
      quad = idx >> qb;
      r = idx & 255;
      if (quad & 1) r = 256 - r;
      s = (quarter_wave(longint'(r) << 22) + 16384) >> 15;
      if (s > 32768) s = 32768;
      sine_q[idx] = quad >= 2 ? -int'(s) : int'(s);
    end
    alg_r = '0;
    inc_r = '{default: '0};
    levels_r = '0;
    fb_r = '0;
    clear_voice();

    plan[0] = '{fmv_pkg::CMD_RENDER, 16'h1000, '{16'd0, 16'd0, 16'd0, 16'd0}, 0, 0};
    plan[1] = '{fmv_pkg::CMD_RENDER, 16'hFFFF,
                '{16'd32768, 16'd32768, 16'd32768, 16'd32768}, 0, 0};
    plan[2] = '{fmv_pkg::CMD_RENDER, 16'h0000, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, 0};
    plan[3] = '{fmv_pkg::CMD_START, 16'hFFFF, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, 0};
    plan[4] = '{fmv_pkg::CMD_RENDER, 16'h1000,
                '{16'd32768, 16'd32768, 16'd32768, 16'd32768}, 0, 0};
    plan[5] = '{fmv_pkg::CMD_RENDER, 16'h1000,
                '{16'd32768, 16'd32768, 16'd32768, 16'd32768}, 0, 0};
    plan[6] = '{fmv_pkg::CMD_RENDER, 16'hFFFF, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, 0};
    plan[7] = '{fmv_pkg::CMD_RENDER, 16'hFFFF, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, 0};
    plan[8] = '{fmv_pkg::CMD_RENDER, 16'h0000, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 0, 0};
    plan[9] = '{fmv_pkg::CMD_RENDER, 16'h0001, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 0, 0};
    plan[10] = '{fmv_pkg::CMD_START, 16'h0000, '{16'd0, 16'd0, 16'd0, 16'd0}, 1, 0};
    plan[11] = '{fmv_pkg::CMD_RENDER, 16'h2000, '{16'd20000, 16'd0, 16'd32768, 16'd1}, 0, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All levels are zero after reset, so every sample is zero.
    for (int k = 0; k < 4; k++) send_item(plan[k].cmd, plan[k].ratio, plan[k].env, 1, 0);
    in_tvalid <= 1'b0;
    drain();

    for (int v = 0; v < 8; v++) begin
      case (v % 4)
        0: set_voice(v[2:0], '1, '1, '1, '1, '1, '1);
        1: set_voice(v[2:0], 32'h0100_0000, 32'h0200_0000, 32'h0080_0000, 32'h0300_0000,
                     64'h4000_7FFF_0001_C000, 64'h0000_0801_0800_0FFF);
        2: set_voice(v[2:0], '0, 32'h1234_5678, '0, 32'h8000_0000,
                     64'h0000_4000_0000_4000, 64'h0400_0000_0001);
        default: set_voice(v[2:0], 32'h0050_0000, 32'h0051_0000, 32'h0052_0000, 32'h0053_0000,
                           64'h2000_2000_2000_2000, 64'h0200_2000_2000_0200);
      endcase
      for (int k = 0; k < 12; k++)
        send_item(plan[k].cmd, plan[k].ratio, plan[k].env, plan[k].typed, plan[k].val);
      in_tvalid <= 1'b0;
      drain();
    end

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 4);
      for (int q = 0; q < 4; q++) begin
        lv[16*q +: 16] = $urandom_range(9) == 0 ? 16'd0 :
                         $urandom_range(9) == 0 ? 16'hFFFF : 16'($urandom_range(16384, 1));
        case ($urandom_range(5))
          0: fb[12*q +: 12] = 12'd0;
          1: fb[12*q +: 12] = fmv_pkg::FB_MAX;
          2: fb[12*q +: 12] = 12'hFFF;
          default: fb[12*q +: 12] = 12'($urandom_range(2048));
        endcase
      end
      fb[63:48] = 16'($urandom);
      set_voice(ph[2:0], $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000), lv, fb);
      for (int k = 0; k < 30; k++) begin
        for (int q = 0; q < 4; q++)
          env[q] = $urandom_range(19) == 0 ? 16'($urandom) : 16'($urandom_range(32768));
        send_item($urandom_range(19) == 0 ? fmv_pkg::CMD_START : fmv_pkg::CMD_RENDER,
                  $urandom_range(4) == 0 ? 16'($urandom) : 16'($urandom_range(4800, 3400)),
                  env, 0, 0);
      end
      in_tvalid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("fm_four_operator_voice regression: pass");
    end else begin
      $display("fm_four_operator_voice regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
